// ===== hdl/lbh_pkg.sv =====
// ----------------------------------------------------------------------------
// lbh_pkg: shared types and constants of the letter bigram histogram
// Request and result structs, request modes, character codes and table sizes.
// ----------------------------------------------------------------------------
package lbh_pkg;

    localparam int MAX_LETTERS_DEF = 19;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int LETTERS = 26;
    localparam int CELLS   = LETTERS * LETTERS;
    localparam int IDX_W   = 10;
    localparam int LTR_W   = 5;
    localparam int KEPT_W  = 5;
    localparam int OUT_W   = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_CELL  = 2'd1,
        MODE_RANK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [7:0]        text_byte;
        logic [IDX_W-1:0]  index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  pair_index;
        logic [OUT_W-1:0]  pair_count;
        logic [OUT_W-1:0]  repeat_words;
        logic              found;
        logic [OUT_W-1:0]  word_total;
        logic [KEPT_W-1:0] longest_word;
        logic [IDX_W-1:0]  distinct_pairs;
        logic [OUT_W-1:0]  pair_total;
        logic              text_done;
    } rsp_t;

    // Control of the word pair buffer
    typedef struct packed {
        logic              we;
        logic [KEPT_W-1:0] wr_slot;
        logic [KEPT_W-1:0] rd_slot;
        logic [IDX_W-1:0]  pair;
    } wb_cmd_t;

endpackage

// ===== hdl/lbh_word_buf.sv =====
// ----------------------------------------------------------------------------
// lbh_word_buf: pairs of the current word
// Holds one pair code per slot and compares a chosen slot with a pair code.
// ----------------------------------------------------------------------------
module lbh_word_buf #(
    parameter int MAX_LETTERS = lbh_pkg::MAX_LETTERS_DEF
) (
    input  logic            clk,
    input  lbh_pkg::wb_cmd_t cmd,
    output logic            hit
);
    import lbh_pkg::*;

    localparam int WP   = MAX_LETTERS - 1;
    localparam int WP_W = (WP > 1) ? $clog2(WP) : 1;

    logic [IDX_W-1:0] pairs_reg [WP];

    // Store the pair at its slot
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            pairs_reg[cmd.wr_slot[WP_W-1:0]] <= cmd.pair;
        end
    end

    // Compare one slot per cycle
    assign hit = (pairs_reg[cmd.rd_slot[WP_W-1:0]] == cmd.pair);

endmodule

// ===== hdl/letter_bigram_histogram.sv =====
// ----------------------------------------------------------------------------
// letter_bigram_histogram: letter pair counts of a text with rank queries
// Counts letter pairs within words in a 26x26 table and answers cell and
// repeat-rank queries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on result for one cycle with done high and cannot be held off. Spaces,
// dots, ignored bytes, the first letter of a word, dropped letters and cell
// reads beyond the table answer in the cycle after the request.
// A kept letter that forms a pair is compared, one compare a cycle, against
// the word's earlier pairs, then the table cell gets a read-modify-write. A
// rank query walks the whole table COUNT_BITS + 2 times (a bitwise search of
// the threshold repeat count, a count above it, a locate pass) through the
// single table read port; a rank that no pair holds stops after the
// COUNT_BITS search passes. A clear, and the clearing pass after reset,
// sweep the 676 table cells; busy is high for both.
// ----------------------------------------------------------------------------
module letter_bigram_histogram #(
    parameter int MAX_LETTERS = lbh_pkg::MAX_LETTERS_DEF,
    parameter int COUNT_BITS  = lbh_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lbh_pkg::req_t req,
    output logic          done,
    output lbh_pkg::rsp_t result
);
    import lbh_pkg::*;

    localparam int CB    = COUNT_BITS;
    localparam int BIT_W = $clog2(CB);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_UPD   = 8'b0001_0000,
        S_SRCH  = 8'b0010_0000,
        S_GT    = 8'b0100_0000,
        S_LOC   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              iss_reg, iss_next;
    logic              pv_reg, pv_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [IDX_W-1:0]  rank_reg, rank_next;
    logic              reply_reg, reply_next;
    logic [KEPT_W-1:0] k_reg, k_next;
    logic [1:0]        prior_reg, prior_next;
    logic [LTR_W-1:0]  letter_reg, letter_next;
    logic [LTR_W-1:0]  last_reg, last_next;
    logic [KEPT_W-1:0] kept_reg, kept_next;
    logic [CB-1:0]     words_reg, words_next;
    logic [KEPT_W-1:0] longest_reg, longest_next;
    logic [IDX_W-1:0]  nonzero_reg, nonzero_next;
    logic [CB-1:0]     sum_reg, sum_next;
    logic              ended_reg, ended_next;
    logic [CB-1:0]     v_reg, v_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [CB-1:0]     res_pc_reg, res_pc_next;
    logic [CB-1:0]     res_rep_reg, res_rep_next;
    logic              res_found_reg, res_found_next;
    logic              done_reg, done_next;

    // Table memory: repeat count above pair count
    logic [2*CB-1:0]   mem [CELLS];
    logic [2*CB-1:0]   rdata_reg;
    logic              we;
    logic [IDX_W-1:0]  wa;
    logic [2*CB-1:0]   wd;

    logic [CB-1:0]     rd_pc, rd_rep;
    logic [7:0]        folded;
    logic              is_letter;
    logic [LTR_W-1:0]  letter;
    logic [IDX_W-1:0]  pair_code;
    logic              pass_last;
    logic [CB-1:0]     thr;
    logic              cmp_hit;
    logic [IDX_W-1:0]  cnt_sum;
    logic              wb_hit;
    wb_cmd_t           wb_cmd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[addr_reg];
    end

    assign rd_pc  = rdata_reg[CB-1:0];
    assign rd_rep = rdata_reg[2*CB-1:CB];

    lbh_word_buf #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_word_buf (
        .clk (clk),
        .cmd (wb_cmd),
        .hit (wb_hit)
    );

    // Fold the byte to lower case and form the pair code
    always_comb
    begin
        folded = req.text_byte;
        if (req.text_byte inside {[CH_A_UP:CH_Z_UP]})
        begin
            folded = req.text_byte | CASE_BIT;
        end
        is_letter = folded inside {[CH_A_LO:CH_Z_LO]};
        letter    = LTR_W'(folded - CH_A_LO);
        pair_code = IDX_W'(IDX_W'(last_reg) * IDX_W'(LETTERS)) + IDX_W'(letter);
    end

    // Shared compare of the table walk
    always_comb
    begin
        thr       = v_reg | (CB'(1) << bit_reg);
        pass_last = pv_reg && (pidx_reg == IDX_W'(CELLS - 1));
        case (state_reg)
            S_SRCH:  cmp_hit = (rd_rep >= thr);
            S_GT:    cmp_hit = (rd_rep > v_reg);
            S_LOC:   cmp_hit = (rd_rep == v_reg);
            default: cmp_hit = 1'b0;
        endcase
        cnt_sum = cnt_reg + IDX_W'(pv_reg && cmp_hit);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        iss_next       = iss_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        rank_next      = rank_reg;
        reply_next     = reply_reg;
        k_next         = k_reg;
        prior_next     = prior_reg;
        letter_next    = letter_reg;
        last_next      = last_reg;
        kept_next      = kept_reg;
        words_next     = words_reg;
        longest_next   = longest_reg;
        nonzero_next   = nonzero_reg;
        sum_next       = sum_reg;
        ended_next     = ended_reg;
        v_next         = v_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        tgt_next       = tgt_reg;
        res_idx_next   = res_idx_reg;
        res_pc_next    = res_pc_reg;
        res_rep_next   = res_rep_reg;
        res_found_next = res_found_reg;
        done_next      = 1'b0;
        we             = 1'b0;
        wa             = addr_reg;
        wd             = '0;
        wb_cmd.we      = 1'b0;
        wb_cmd.wr_slot = kept_reg - KEPT_W'(1);
        wb_cmd.rd_slot = k_reg;
        wb_cmd.pair    = addr_reg;

        // Advance the table walk address
        if ((state_reg == S_SRCH) || (state_reg == S_GT) || (state_reg == S_LOC))
        begin
            if (iss_reg)
            begin
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == IDX_W'(CELLS - 1))
                begin
                    iss_next = 1'b0;
                end
            end
            pv_next   = iss_reg;
            pidx_next = addr_reg;
            cnt_next  = cnt_sum;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next      = req.mode;
                    rank_next      = req.index;
                    res_idx_next   = '0;
                    res_pc_next    = '0;
                    res_rep_next   = '0;
                    res_found_next = 1'b0;
                    case (req.mode)
                        MODE_TEXT:
                        begin
                            done_next = 1'b1;
                            if (!ended_reg && is_letter)
                            begin
                                if (kept_reg == '0)
                                begin
                                    last_next = letter;
                                    kept_next = KEPT_W'(1);
                                end
                                else if (kept_reg < KEPT_W'(MAX_LETTERS))
                                begin
                                    done_next   = 1'b0;
                                    addr_next   = pair_code;
                                    letter_next = letter;
                                    k_next      = '0;
                                    prior_next  = '0;
                                    state_next  = (kept_reg == KEPT_W'(1)) ? S_FETCH : S_SCAN;
                                end
                            end
                            else if (!ended_reg &&
                                     ((req.text_byte == CH_SPACE) || (req.text_byte == CH_DOT)))
                            begin
                                if (kept_reg != '0)
                                begin
                                    words_next = (&words_reg) ? words_reg
                                                              : words_reg + CB'(1);
                                    if (kept_reg > longest_reg)
                                    begin
                                        longest_next = kept_reg;
                                    end
                                    kept_next = '0;
                                end
                                if (req.text_byte == CH_DOT)
                                begin
                                    ended_next = 1'b1;
                                end
                            end
                        end
                        MODE_CELL:
                        begin
                            if (req.index < IDX_W'(CELLS))
                            begin
                                addr_next  = req.index;
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        MODE_RANK:
                        begin
                            v_next     = '0;
                            bit_next   = BIT_W'(CB - 1);
                            addr_next  = '0;
                            iss_next   = 1'b1;
                            pv_next    = 1'b0;
                            cnt_next   = '0;
                            state_next = S_SRCH;
                        end
                        MODE_CLEAR:
                        begin
                            last_next    = '0;
                            kept_next    = '0;
                            words_next   = '0;
                            longest_next = '0;
                            nonzero_next = '0;
                            sum_next     = '0;
                            ended_next   = 1'b0;
                            addr_next    = '0;
                            reply_next   = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Sweep the table to zero
            S_CLEAR:
            begin
                we = 1'b1;
                if (addr_reg == IDX_W'(CELLS - 1))
                begin
                    done_next  = reply_reg;
                    reply_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end

            // Count earlier occurrences of the pair in this word
            S_SCAN:
            begin
                if (wb_hit && (prior_reg != 2'd2))
                begin
                    prior_next = prior_reg + 2'd1;
                end
                k_next = k_reg + KEPT_W'(1);
                if (k_reg == kept_reg - KEPT_W'(2))
                begin
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                state_next = S_UPD;
            end

            // Report the cell, or update it with the new pair
            S_UPD:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (mode_reg == MODE_CELL)
                begin
                    res_idx_next   = addr_reg;
                    res_pc_next    = rd_pc;
                    res_rep_next   = rd_rep;
                    res_found_next = 1'b1;
                end
                else
                begin
                    we               = 1'b1;
                    wd[CB-1:0]       = (&rd_pc) ? rd_pc : rd_pc + CB'(1);
                    wd[2*CB-1:CB]    = ((prior_reg == 2'd1) && !(&rd_rep))
                                       ? rd_rep + CB'(1) : rd_rep;
                    wb_cmd.we        = 1'b1;
                    if (rd_pc == '0)
                    begin
                        nonzero_next = nonzero_reg + IDX_W'(1);
                    end
                    sum_next  = (&sum_reg) ? sum_reg : sum_reg + CB'(1);
                    last_next = letter_reg;
                    kept_next = kept_reg + KEPT_W'(1);
                end
            end

            // Settle one threshold bit per pass
            S_SRCH:
            begin
                if (pass_last)
                begin
                    addr_next = '0;
                    iss_next  = 1'b1;
                    pv_next   = 1'b0;
                    cnt_next  = '0;
                    if (cnt_sum > rank_reg)
                    begin
                        v_next = thr;
                    end
                    if (bit_reg != '0)
                    begin
                        bit_next = bit_reg - BIT_W'(1);
                    end
                    else if ((cnt_sum > rank_reg) || (v_reg != '0))
                    begin
                        state_next = S_GT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            // Count pairs ranked above the threshold
            S_GT:
            begin
                if (pass_last)
                begin
                    tgt_next   = rank_reg - cnt_sum;
                    addr_next  = '0;
                    iss_next   = 1'b1;
                    pv_next    = 1'b0;
                    cnt_next   = '0;
                    state_next = S_LOC;
                end
            end

            // Pick the pair at the remaining rank among equals
            S_LOC:
            begin
                if (pv_reg && cmp_hit && (cnt_reg == tgt_reg) && !res_found_reg)
                begin
                    res_idx_next   = pidx_reg;
                    res_pc_next    = rd_pc;
                    res_rep_next   = rd_rep;
                    res_found_next = 1'b1;
                end
                if (pass_last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mode_reg    <= MODE_TEXT;
            addr_reg    <= '0;
            iss_reg     <= 1'b0;
            pv_reg      <= 1'b0;
            pidx_reg    <= '0;
            reply_reg   <= 1'b0;
            k_reg       <= '0;
            prior_reg   <= '0;
            last_reg    <= '0;
            kept_reg    <= '0;
            words_reg   <= '0;
            longest_reg <= '0;
            nonzero_reg <= '0;
            sum_reg     <= '0;
            ended_reg   <= 1'b0;
            bit_reg     <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            addr_reg    <= addr_next;
            iss_reg     <= iss_next;
            pv_reg      <= pv_next;
            pidx_reg    <= pidx_next;
            reply_reg   <= reply_next;
            k_reg       <= k_next;
            prior_reg   <= prior_next;
            last_reg    <= last_next;
            kept_reg    <= kept_next;
            words_reg   <= words_next;
            longest_reg <= longest_next;
            nonzero_reg <= nonzero_next;
            sum_reg     <= sum_next;
            ended_reg   <= ended_next;
            bit_reg     <= bit_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rank_reg      <= rank_next;
        letter_reg    <= letter_next;
        v_reg         <= v_next;
        tgt_reg       <= tgt_next;
        res_idx_reg   <= res_idx_next;
        res_pc_reg    <= res_pc_next;
        res_rep_reg   <= res_rep_next;
        res_found_reg <= res_found_next;
    end

    // Drive the result
    always_comb
    begin
        logic [31:0] pc32, rep32, words32, sum32;
        pc32    = 32'(res_pc_reg);
        rep32   = 32'(res_rep_reg);
        words32 = 32'(words_reg);
        sum32   = 32'(sum_reg);
        result.pair_index     = res_idx_reg;
        result.pair_count     = pc32[OUT_W-1:0];
        result.repeat_words   = rep32[OUT_W-1:0];
        result.found          = res_found_reg;
        result.word_total     = words32[OUT_W-1:0];
        result.longest_word   = longest_reg;
        result.distinct_pairs = nonzero_reg;
        result.pair_total     = sum32[OUT_W-1:0];
        result.text_done      = ended_reg;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_kept_max: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KEPT_W'(MAX_LETTERS))
        else $error("kept letters beyond limit");

    a_cells_max: assert property (@(posedge clk) disable iff (!rst_n)
        nonzero_reg <= IDX_W'(CELLS))
        else $error("distinct pair count beyond table size");

endmodule

// ===== tb/letter_bigram_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// letter_bigram_histogram_tb: self-checking bench of the letter bigram histogram
// Sends text, cell, rank and clear requests. A predictor in the bench keeps
// its own copy of the tables and works out each result, and every done strobe
// is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module letter_bigram_histogram_tb;
    import lbh_pkg::*;

    localparam int MAX_KEPT = MAX_LETTERS_DEF;
    localparam int SAT      = 65535;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  result;

    int    gap_pct;
    int    mismatches;
    rsp_t  expected_q[$];

    // Predictor state
    int    cell_count[CELLS];
    int    cell_repeat[CELLS];
    int    word_buf[MAX_KEPT];
    int    kept;
    int    prev_letter;
    int    words;
    int    longest;
    int    nonzero;
    int    occ_sum;
    bit    ended;

    letter_bigram_histogram DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hold off a hung run
    initial
    begin
        #(12 * 40_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int sat_inc(int v);
        return (v < SAT) ? v + 1 : SAT;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < CELLS; i++)
        begin
            cell_count[i]  = 0;
            cell_repeat[i] = 0;
        end
        kept = 0; prev_letter = 0; words = 0; longest = 0;
        nonzero = 0; occ_sum = 0; ended = 0;
    endfunction

    function automatic void close_word();
        if (kept == 0)
            return;
        words = sat_inc(words);
        if (kept > longest)
            longest = kept;
        kept = 0;
    endfunction

    function automatic void add_letter(int ltr);
        int p;
        int prior;
        if (kept >= MAX_KEPT)
            return;
        if (kept > 0)
        begin
            p = prev_letter * LETTERS + ltr;
            prior = 0;
            for (int k = 0; k < kept - 1; k++)
                if (word_buf[k] == p)
                    prior++;
            if (prior == 1)
                cell_repeat[p] = sat_inc(cell_repeat[p]);
            word_buf[kept - 1] = p;
            if (cell_count[p] == 0)
                nonzero++;
            cell_count[p] = sat_inc(cell_count[p]);
            occ_sum = sat_inc(occ_sum);
        end
        prev_letter = ltr;
        kept++;
    endfunction

    function automatic int rank_cell(int rank);
        int pos;
        for (int i = 0; i < CELLS; i++)
        begin
            if (cell_repeat[i] == 0)
                continue;
            pos = 0;
            for (int j = 0; j < CELLS; j++)
                if (cell_repeat[j] > cell_repeat[i] ||
                    (cell_repeat[j] == cell_repeat[i] && j < i))
                    pos++;
            if (pos == rank)
                return i;
        end
        return CELLS;
    endfunction

    // Advance the predictor by one request and return its result
    function automatic rsp_t predict_histogram(req_t r);
        rsp_t o;
        logic [7:0] b;
        int hit_idx;
        o = '0;
        hit_idx = CELLS;
        case (r.mode)
            MODE_TEXT:
            begin
                b = r.text_byte;
                if (!ended)
                begin
                    if (b >= CH_A_UP && b <= CH_Z_UP)
                        b = b | CASE_BIT;
                    if (b >= CH_A_LO && b <= CH_Z_LO)
                        add_letter(int'(b - CH_A_LO));
                    else if (b == CH_SPACE)
                        close_word();
                    else if (b == CH_DOT)
                    begin
                        close_word();
                        ended = 1;
                    end
                end
            end
            MODE_CELL:
                if (r.index < CELLS)
                    hit_idx = int'(r.index);
            MODE_RANK:
                hit_idx = rank_cell(int'(r.index));
            default:
                clear_model();
        endcase
        if (hit_idx < CELLS)
        begin
            o.pair_index   = IDX_W'(hit_idx);
            o.pair_count   = OUT_W'(cell_count[hit_idx]);
            o.repeat_words = OUT_W'(cell_repeat[hit_idx]);
            o.found        = 1'b1;
        end
        o.word_total     = OUT_W'(words);
        o.longest_word   = KEPT_W'(longest);
        o.distinct_pairs = IDX_W'(nonzero);
        o.pair_total     = OUT_W'(occ_sum);
        o.text_done      = ended;
        return o;
    endfunction

    // Send one request, with a random idle gap before it
    task automatic send_request(mode_t m, logic [7:0] b, logic [9:0] idx);
        req_t r;
        r.mode = m; r.text_byte = b; r.index = idx;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(predict_histogram(r));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(MODE_TEXT, s[i], 10'($urandom_range(1023)));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p", result);
            end
            else
            begin
                rsp_t e;
                e = expected_q.pop_front();
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, result);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(MODE_CELL, 8'h00, 10'd0);
        send_request(MODE_RANK, 8'h00, 10'd0);
        send_text("AbAb zZ");
        send_request(MODE_TEXT, 8'hFF, 10'h3FF);
        send_request(MODE_TEXT, 8'h0A, 10'd0);
        send_text("xx ");
        send_request(MODE_CELL, 8'h00, 10'd27);
        send_request(MODE_CELL, 8'h00, 10'd675);
        send_request(MODE_CELL, 8'h00, 10'd676);
        send_request(MODE_CELL, 8'h00, 10'h3FF);
        send_request(MODE_RANK, 8'h00, 10'd1);
        send_request(MODE_RANK, 8'h00, 10'd5);
        send_request(MODE_CLEAR, 8'h00, 10'd0);
    endtask

    task automatic test_long_words();
        send_text("abababababababababababababab ..");
        send_text("q");
        send_request(MODE_RANK, 8'h00, 10'd0);
        send_request(MODE_RANK, 8'h00, 10'd1);
        send_request(MODE_CLEAR, 8'h00, 10'd0);
    endtask

    // Mostly words built from few letters, so pairs repeat often
    task automatic test_random(int n);
        int len;
        logic [7:0] c;
        while (n > 0)
        begin
            if ($urandom_range(99) < 75)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 20)
                                               : $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                begin
                    c = 8'(8'h61 + $urandom_range(3));
                    if ($urandom_range(1))
                        c = c & ~CASE_BIT;
                    send_request(MODE_TEXT, c, 10'($urandom_range(1023)));
                end
                send_request(MODE_TEXT, $urandom_range(60) == 0 ? CH_DOT : CH_SPACE,
                             10'($urandom_range(1023)));
                n -= len + 1;
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2: send_request(MODE_TEXT, 8'($urandom_range(255)),
                                          10'($urandom_range(1023)));
                    3, 4, 5: send_request(MODE_CELL, 8'($urandom_range(255)),
                                          $urandom_range(1) ? 10'($urandom_range(1023))
                                                            : 10'($urandom_range(107)));
                    6, 7: send_request(MODE_RANK, 8'($urandom_range(255)),
                                       10'($urandom_range(7)));
                    8: send_request(MODE_RANK, 8'($urandom_range(255)),
                                    10'($urandom_range(1023)));
                    default:
                        if ($urandom_range(3) == 0)
                            send_request(MODE_CLEAR, 8'($urandom_range(255)),
                                         10'($urandom_range(1023)));
                        else
                            send_request(MODE_TEXT, CH_SPACE, 10'd0);
                endcase
                n--;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        gap_pct    = 30;
        mismatches = 0;
        clear_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_long_words();
        test_random(250);
        gap_pct = 78;
        test_random(250);
        gap_pct = 0;
        test_random(250);
        wait_drained();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
